@@ rtl/sfe_pkg.sv @@
package sfe_pkg;

  localparam logic [7:0]  ByteStx  = 8'h02;
  localparam logic [7:0]  ByteEsc  = 8'h10;
  localparam logic [7:0]  ByteFlag = 8'h80;
  localparam logic [15:0] CrcPoly  = 16'h8005;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic ReqStart = 1'b0;
  localparam logic ReqParam = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PARAM,
    CMD_ERROR
  } cmd_kind_t;

  // one classified input item travelling from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;
    logic [7:0] count;
    logic       crc_after;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STX,
    PH_LEN0,
    PH_LEN1,
    PH_VAL,
    PH_CRCHI,
    PH_CRCLO
  } phase_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  v;
    logic        top;
    c = crc;
    v = b;
    for (int i = 0; i < 8; i++) begin
      top = c[15] ^ v[7];
      c   = {c[14:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
      v = {v[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/sfe_in_if.sv @@
interface sfe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;
  logic [7:0] param_count;

  modport source (output valid, output req_type, output byte_value, output param_count,
                  input ready);
  modport sink (input valid, input req_type, input byte_value, input param_count,
                output ready);
endinterface

@@ rtl/sfe_out_if.sv @@
interface sfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       last_of_run;
  logic       frame_end;
  logic       seq_error;

  modport source (output valid, output wire_byte, output last_of_run, output frame_end,
                  output seq_error, input ready);
  modport sink (input valid, input wire_byte, input last_of_run, input frame_end,
                input seq_error, output ready);
endinterface

@@ rtl/sfe_front.sv @@
module sfe_front (
  input  logic          clk,
  input  logic          rst,
  sfe_in_if.sink        cmd,
  output sfe_pkg::cmd_t q_data,
  output logic          q_push,
  input  logic          q_full
);
  import sfe_pkg::*;

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] params_left;
  logic [7:0] params_left_next;
  logic       accept;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && !q_full;
  assign q_push    = accept;

  always_comb begin
    q_data           = '0;
    q_data.value     = cmd.byte_value;
    q_data.count     = cmd.param_count;
    frame_open_next  = frame_open;
    params_left_next = params_left;
    if (cmd.req_type == ReqStart) begin
      q_data.kind      = CMD_START;
      q_data.crc_after = (cmd.param_count == 8'd0);
      frame_open_next  = (cmd.param_count != 8'd0);
      params_left_next = cmd.param_count;
    end else if (!frame_open) begin
      q_data.kind = CMD_ERROR;
    end else begin
      q_data.kind      = CMD_PARAM;
      q_data.crc_after = (params_left == 8'd1);
      params_left_next = params_left - 8'd1;
      frame_open_next  = (params_left != 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      params_left <= '0;
    end else if (accept) begin
      frame_open  <= frame_open_next;
      params_left <= params_left_next;
    end
  end

endmodule

@@ rtl/sfe_fifo.sv @@
module sfe_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfe_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output sfe_pkg::cmd_t rd_data,
  output logic          not_empty
);
  import sfe_pkg::*;

  cmd_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == QCntW'(QDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/sfe_back.sv @@
module sfe_back (
  input  logic          clk,
  input  logic          rst,
  input  sfe_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  sfe_out_if.source     tx
);
  import sfe_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      cur_phase;
  logic        esc_second;
  logic        esc_second_next;
  logic [15:0] crc;
  logic [15:0] crc_new;
  logic [15:0] snap;
  logic        emit;
  logic        is_err;
  logic [7:0]  raw;
  logic        need_esc;
  logic        byte_done;
  logic [7:0]  obyte;
  logic        olast;
  logic        oend;

  logic        ov;
  logic [7:0]  o_byte;
  logic        o_last;
  logic        o_end;
  logic        o_err;

  assign emit   = head_valid && (!ov || tx.ready);
  assign is_err = (head.kind == CMD_ERROR);

  // output decode of the current phase
  always_comb begin
    if (phase == PH_IDLE) begin
      cur_phase = (head.kind == CMD_START) ? PH_STX : PH_VAL;
    end else begin
      cur_phase = phase;
    end
    case (cur_phase)
      PH_STX:   raw = ByteStx;
      PH_LEN0:  raw = 8'd0;
      PH_LEN1:  raw = head.count + 8'd1;
      PH_VAL:   raw = head.value;
      PH_CRCHI: raw = snap[15:8];
      PH_CRCLO: raw = snap[7:0];
      default:  raw = 8'd0;
    endcase
    need_esc = (cur_phase != PH_STX) && ((raw == ByteStx) || (raw == ByteEsc));
    if (need_esc && !esc_second) begin
      obyte     = ByteEsc;
      byte_done = 1'b0;
    end else begin
      obyte     = esc_second ? (raw | ByteFlag) : raw;
      byte_done = 1'b1;
    end
    olast = is_err || (byte_done &&
            ((cur_phase == PH_VAL && !head.crc_after) || cur_phase == PH_CRCLO));
    oend  = !is_err && byte_done && (cur_phase == PH_CRCLO);
    if (is_err) begin
      obyte = 8'd0;
    end
    crc_new = crc_update((cur_phase == PH_STX) ? CrcInit : crc, obyte);
  end

  // next phase
  always_comb begin
    phase_next      = phase;
    esc_second_next = esc_second;
    if (emit && !is_err) begin
      esc_second_next = need_esc && !esc_second;
      if (byte_done) begin
        case (cur_phase)
          PH_STX:   phase_next = PH_LEN0;
          PH_LEN0:  phase_next = PH_LEN1;
          PH_LEN1:  phase_next = PH_VAL;
          PH_VAL:   phase_next = head.crc_after ? PH_CRCHI : PH_IDLE;
          PH_CRCHI: phase_next = PH_CRCLO;
          PH_CRCLO: phase_next = PH_IDLE;
          default:  phase_next = PH_IDLE;
        endcase
      end
    end
  end

  assign pop = emit && olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      esc_second <= 1'b0;
      crc        <= CrcInit;
    end else begin
      phase      <= phase_next;
      esc_second <= esc_second_next;
      if (emit && !is_err) begin
        crc <= crc_new;
      end
    end
  end

  // checksum is frozen once the last value byte has gone through it
  always_ff @(posedge clk) begin
    if (emit && !is_err && byte_done && cur_phase == PH_VAL) begin
      snap <= crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (tx.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte <= obyte;
      o_last <= olast;
      o_end  <= oend;
      o_err  <= is_err;
    end
  end

  assign tx.valid       = ov;
  assign tx.wire_byte   = o_byte;
  assign tx.last_of_run = o_last;
  assign tx.frame_end   = o_end;
  assign tx.seq_error   = o_err;

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    ov && o_end |-> o_last)
    else $error("frame end beat not marked last");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    ov && o_err |-> o_last && !o_end && o_byte == 8'd0)
    else $error("error beat malformed");

  // a parameter byte keeps the idle phase while its escape is pending
  a_esc_phase: assert property (@(posedge clk) disable iff (rst)
    esc_second |-> head_valid && phase != PH_STX)
    else $error("escape pending outside a byte");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop && !is_err |=> phase == PH_IDLE && !esc_second)
    else $error("item retired mid sequence");

endmodule

@@ rtl/stuffed_frame_encoder_crc16_core.sv @@
// Serial command frame encoder. A start item sends STX, the escaped length bytes 0 and
// 1+count and the escaped command byte; each parameter item sends its escaped byte; the
// escaped CRC-16 (poly 0x8005, init 0xFFFF, over every wire byte from STX up to it) follows
// the last parameter, or the command byte when count is 0. A parameter with no open frame
// gives one beat with seq_error set. The front classifies items into a two-entry queue and
// takes a new item every cycle while the queue has room; the back sends one wire byte per
// cycle through an output register while tx is ready, and an item has 1 or 2 output beats
// for a parameter, 4 to 6 for a start, plus 2 to 4 when the CRC is appended.
module stuffed_frame_encoder_crc16_core (
  input  logic      clk,
  input  logic      rst,
  sfe_in_if.sink    cmd,
  sfe_out_if.source tx
);
  import sfe_pkg::*;

  cmd_t q_wr;
  cmd_t q_head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  sfe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_data (q_wr),
    .q_push (q_push),
    .q_full (q_full)
  );

  sfe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (q_head),
    .not_empty (q_valid)
  );

  sfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .tx         (tx)
  );

endmodule
